@@ sv/bpra_pkg.sv @@
// Shared constants and types of the bitmap page run allocator.
// Used by every module of the block; has no dependencies.
package bpra_pkg;
  localparam int MAX_POOL_PAGES = 16384;
  localparam int PAGE_SHIFT = 12;
  localparam int WORDS = MAX_POOL_PAGES / 32;
  localparam int WORD_W = $clog2(WORDS);
  localparam int PAGE_W = 15;
  localparam int IDX_W = $clog2(MAX_POOL_PAGES);

  localparam logic [31:0] RESET_BASE = 32'h0010_0000;
  localparam logic [PAGE_W-1:0] RESET_POOL_PAGES = 15'd16128;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_POOL = 1'b1;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_UPD_RD = 7'b0001000,
    S_UPD_WR = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  start;
    logic [PAGE_W-1:0] run_out;
  } scan_res_t;
endpackage

@@ sv/bpra_if.sv @@
// Channel interfaces of the allocator: request, response and configuration.
// Depends on bpra_pkg for field widths.
interface bpra_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bpra_pkg::PAGE_W-1:0] page_count;
  logic [31:0]                 address;
  modport source (output valid, mode, page_count, address, input ready);
  modport sink (input valid, mode, page_count, address, output ready);
endinterface

interface bpra_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] run_address;
  modport source (output valid, status, run_address, input ready);
  modport sink (input valid, status, run_address, output ready);
endinterface

interface bpra_cfg_if;
  logic        valid;
  logic        ready;
  logic        reg_index;
  logic [31:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

@@ sv/bpra_bitmap_ram.sv @@
// Page occupancy bitmap storage: one write and one registered read port.
// Depends on bpra_pkg for depth and address width.
module bpra_bitmap_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [bpra_pkg::WORD_W-1:0] wr_addr,
  input  logic [31:0]                 wr_data,
  input  logic                        rd_en,
  input  logic [bpra_pkg::WORD_W-1:0] rd_addr,
  output logic [31:0]                 rd_data
);
  logic [31:0] mem [bpra_pkg::WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ sv/bpra_word_scan.sv @@
// Evaluates one bitmap word for the first-fit search, carrying the free run.
// Depends on bpra_pkg for widths and the result struct.
module bpra_word_scan (
  input  logic [31:0]                 word,
  input  logic [bpra_pkg::WORD_W-1:0] word_idx,
  input  logic [bpra_pkg::PAGE_W-1:0] pool,
  input  logic [bpra_pkg::PAGE_W-1:0] count,
  input  logic [bpra_pkg::PAGE_W-1:0] run_in,
  output bpra_pkg::scan_res_t         res
);
  logic [31:0] eff;
  logic [5:0]  tz;
  logic [4:0]  lz;
  logic [32:0] ones;
  logic [31:0] m;
  logic        hit;
  logic [4:0]  first_s;
  logic [15:0] cross_len;
  logic [bpra_pkg::IDX_W-1:0] wbase;

  assign wbase = {word_idx, 5'd0};

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      eff[b] = word[b] | ({1'b0, word_idx, 5'(b)} >= pool);
    end
  end

  always_comb begin
    tz = 6'd32;
    lz = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (eff[b]) tz = 6'(b);
    end
    for (int b = 0; b < 32; b++) begin
      if (eff[b]) lz = 5'(31 - b);
    end
  end

  always_comb begin
    ones = (33'd1 << count[5:0]) - 33'd1;
    m = ones[31:0];
    hit = 1'b0;
    first_s = 5'd0;
    for (int s = 31; s >= 0; s--) begin
      if ((count <= 15'd32) && ((15'(s) + count) <= 15'd32) && ((eff & (m << s)) == 32'd0)) begin
        hit = 1'b1;
        first_s = 5'(s);
      end
    end
  end

  assign cross_len = {1'b0, run_in} + {10'd0, tz};

  always_comb begin
    res.found = 1'b0;
    res.start = '0;
    priority if (cross_len >= {1'b0, count}) begin
      res.found = 1'b1;
      res.start = wbase - run_in[bpra_pkg::IDX_W-1:0];
    end else if (hit) begin
      res.found = 1'b1;
      res.start = wbase + {{(bpra_pkg::IDX_W-5){1'b0}}, first_s};
    end
    res.run_out = (eff == 32'd0) ? run_in + 15'd32 : {10'd0, lz};
  end
endmodule

@@ sv/bitmap_page_run_allocator.sv @@
// Top level of the bitmap page run allocator: control sequencer and registers.
// Depends on bpra_pkg, the channel interfaces, bpra_bitmap_ram and bpra_word_scan.
//
// Requests arrive on req: mode 0 allocates page_count contiguous pages, mode 1
// frees page_count pages from address. Each request gives one response on rsp
// with a status and, for a successful allocate, the run address.
// Configuration (base_address index 0, pool_pages index 1) is written on cfg,
// which is always ready; write it only while no request is in flight.
// After reset all 512 words of the bitmap are swept clear, one word a cycle;
// req is not ready during that sweep.
// An allocate reads the bitmap one word a cycle, up to the word holding the
// found run or the last word of the pool, then reads and writes back each
// word of the run to mark it used. A free reads and writes back each word
// touched. Rejected requests go straight to the finish state. One request is
// worked at a time.
// The response sits in an output register; a new request is taken while it
// waits, and a finished result stalls until the previous response is taken.
module bitmap_page_run_allocator (
  input  logic           clk,
  input  logic           rst,
  bpra_req_if.sink       req,
  bpra_rsp_if.source     rsp,
  bpra_cfg_if.sink       cfg
);
  bpra_pkg::state_t state;

  logic [31:0]                     base_address;
  logic [bpra_pkg::PAGE_W-1:0]     pool_pages;
  logic [bpra_pkg::PAGE_W-1:0]     pool;
  logic [bpra_pkg::WORD_W-1:0]     last_word;
  logic [bpra_pkg::WORD_W-1:0]     clr_w;
  logic [bpra_pkg::WORD_W:0]       scan_rd_w;
  logic [bpra_pkg::WORD_W-1:0]     ev_w;
  logic                            ev_v;
  logic [bpra_pkg::PAGE_W-1:0]     run;
  logic [bpra_pkg::PAGE_W-1:0]     count;
  logic [bpra_pkg::IDX_W-1:0]      lo;
  logic [bpra_pkg::IDX_W-1:0]      hi_m1;
  logic                            set_bits;
  logic [bpra_pkg::WORD_W-1:0]     upd_w;
  logic [1:0]                      res_status;
  logic [31:0]                     res_addr;

  logic                            rd_en;
  logic [bpra_pkg::WORD_W-1:0]     rd_addr;
  logic [31:0]                     rd_data;
  logic                            wr_en;
  logic [bpra_pkg::WORD_W-1:0]     wr_addr;
  logic [31:0]                     wr_data;
  logic [31:0]                     mask;
  logic [bpra_pkg::WORD_W-1:0]     upd_last;
  logic [bpra_pkg::PAGE_W-1:0]     pool_m1;
  bpra_pkg::scan_res_t             scan;

  logic [31:0]                     off;
  logic [31-bpra_pkg::PAGE_SHIFT:0] fidx;
  logic [15:0]                     fend;
  logic [bpra_pkg::IDX_W-1:0]      fhi_m1;

  assign pool = (pool_pages > 15'(bpra_pkg::MAX_POOL_PAGES)) ?
                15'(bpra_pkg::MAX_POOL_PAGES) : pool_pages;
  assign pool_m1 = pool - 15'd1;
  assign last_word = pool_m1[bpra_pkg::IDX_W-1:5];
  assign upd_last = hi_m1[bpra_pkg::IDX_W-1:5];

  assign off = req.address - base_address;
  assign fidx = off[31:bpra_pkg::PAGE_SHIFT];
  assign fend = {2'd0, fidx[bpra_pkg::IDX_W-1:0]} + {1'b0, req.page_count};
  assign fhi_m1 = (fend > {1'b0, pool}) ? pool_m1[bpra_pkg::IDX_W-1:0] :
                  fend[bpra_pkg::IDX_W-1:0] - 14'd1;

  assign req.ready = (state == bpra_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    mask = 32'hFFFF_FFFF;
    if (upd_w == lo[bpra_pkg::IDX_W-1:5]) mask = mask & (32'hFFFF_FFFF << lo[4:0]);
    if (upd_w == upd_last) mask = mask & (32'hFFFF_FFFF >> (5'd31 - hi_m1[4:0]));
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = upd_w;
    wr_en = 1'b0;
    wr_addr = upd_w;
    wr_data = set_bits ? (rd_data | mask) : (rd_data & ~mask);
    unique case (state)
      bpra_pkg::S_SCAN: begin
        rd_en = (scan_rd_w <= {1'b0, last_word});
        rd_addr = scan_rd_w[bpra_pkg::WORD_W-1:0];
      end
      bpra_pkg::S_UPD_RD: rd_en = 1'b1;
      bpra_pkg::S_UPD_WR: wr_en = 1'b1;
      bpra_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_w;
        wr_data = 32'd0;
      end
      default: ;
    endcase
  end

  bpra_bitmap_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bpra_word_scan u_scan (
    .word     (rd_data),
    .word_idx (ev_w),
    .pool     (pool),
    .count    (count),
    .run_in   (run),
    .res      (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpra_pkg::S_CLEAR;
      clr_w <= '0;
      base_address <= bpra_pkg::RESET_BASE;
      pool_pages <= bpra_pkg::RESET_POOL_PAGES;
      rsp.valid <= 1'b0;
      ev_v <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.reg_index)
          bpra_pkg::REG_BASE: base_address <= cfg.data;
          bpra_pkg::REG_POOL: pool_pages <= cfg.data[bpra_pkg::PAGE_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && state != bpra_pkg::S_FINISH) rsp.valid <= 1'b0;
      unique case (state)
        bpra_pkg::S_CLEAR: begin
          clr_w <= clr_w + 9'd1;
          if (clr_w == 9'(bpra_pkg::WORDS - 1)) state <= bpra_pkg::S_IDLE;
        end
        bpra_pkg::S_IDLE: begin
          if (req.valid) begin
            count <= req.page_count;
            res_addr <= 32'd0;
            if (req.mode == bpra_pkg::MODE_ALLOC) begin
              set_bits <= 1'b1;
              if (req.page_count == 15'd0 || req.page_count > pool) begin
                res_status <= bpra_pkg::ST_NO_SPACE;
                state <= bpra_pkg::S_FINISH;
              end else begin
                res_status <= bpra_pkg::ST_OK;
                scan_rd_w <= '0;
                ev_v <= 1'b0;
                run <= '0;
                state <= bpra_pkg::S_SCAN;
              end
            end else begin
              set_bits <= 1'b0;
              lo <= fidx[bpra_pkg::IDX_W-1:0];
              hi_m1 <= fhi_m1;
              upd_w <= fidx[bpra_pkg::IDX_W-1:5];
              if (fidx >= {{(32-bpra_pkg::PAGE_SHIFT-bpra_pkg::PAGE_W){1'b0}}, pool}) begin
                res_status <= bpra_pkg::ST_OUTSIDE;
                state <= bpra_pkg::S_FINISH;
              end else begin
                res_status <= bpra_pkg::ST_OK;
                if (req.page_count == 15'd0) begin
                  state <= bpra_pkg::S_FINISH;
                end else begin
                  state <= bpra_pkg::S_UPD_RD;
                end
              end
            end
          end
        end
        bpra_pkg::S_SCAN: begin
          ev_v <= rd_en;
          ev_w <= scan_rd_w[bpra_pkg::WORD_W-1:0];
          if (rd_en) scan_rd_w <= scan_rd_w + 10'd1;
          if (ev_v) begin
            run <= scan.run_out;
            if (scan.found) begin
              lo <= scan.start;
              hi_m1 <= scan.start + count[bpra_pkg::IDX_W-1:0] - 14'd1;
              upd_w <= scan.start[bpra_pkg::IDX_W-1:5];
              res_addr <= base_address +
                          ({18'd0, scan.start} << bpra_pkg::PAGE_SHIFT);
              state <= bpra_pkg::S_UPD_RD;
            end else if (ev_w == last_word) begin
              res_status <= bpra_pkg::ST_NO_SPACE;
              state <= bpra_pkg::S_FINISH;
            end
          end
        end
        bpra_pkg::S_UPD_RD: state <= bpra_pkg::S_UPD_WR;
        bpra_pkg::S_UPD_WR: begin
          if (upd_w == upd_last) begin
            state <= bpra_pkg::S_FINISH;
          end else begin
            upd_w <= upd_w + 9'd1;
            state <= bpra_pkg::S_UPD_RD;
          end
        end
        bpra_pkg::S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.status <= res_status;
            rsp.run_address <= res_addr;
            state <= bpra_pkg::S_IDLE;
          end
        end
        default: state <= bpra_pkg::S_IDLE;
      endcase
    end
  end

  a_wr_only_clear_or_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == bpra_pkg::S_CLEAR || state == bpra_pkg::S_UPD_WR))
    else $error("bitmap written outside clear or update");

  a_fail_has_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != bpra_pkg::ST_OK) |-> rsp.run_address == 32'd0)
    else $error("failed request carries an address");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::S_SCAN) |-> scan_rd_w <= {1'b0, last_word} + 10'd1)
    else $error("scan read past pool end");

  a_upd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::S_UPD_WR) |-> upd_w <= upd_last)
    else $error("update pass past run end");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::S_CLEAR) |=> !$past(req.ready))
    else $error("request accepted during clearing sweep");
endmodule

@@ test/alloc_checker.sv @@
// Checker for the bitmap page run allocator: watches the request, response and
// configuration channels, predicts each response and compares. Uses bpra_pkg.
module alloc_checker (
  input  logic        clk,
  input  logic        rst,
  bpra_req_if         req,
  bpra_rsp_if         rsp,
  bpra_cfg_if         cfg,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] run_address;
  } alloc_resp_t;

  logic [31:0] base_reg;
  logic [bpra_pkg::PAGE_W-1:0] pool_reg;
  bit page_map [bpra_pkg::MAX_POOL_PAGES];
  alloc_resp_t resp_queue[$];

  function automatic alloc_resp_t predict_request(logic mode,
                                                  logic [bpra_pkg::PAGE_W-1:0] cnt,
                                                  logic [31:0] addr);
    int unsigned pool;
    int unsigned run_len;
    int unsigned first;
    int unsigned idx;
    int unsigned stop;
    bit found;
    alloc_resp_t r;
    pool = (pool_reg > bpra_pkg::MAX_POOL_PAGES) ? bpra_pkg::MAX_POOL_PAGES : pool_reg;
    r.status = bpra_pkg::ST_OK;
    r.run_address = '0;
    found = 0;
    first = 0;
    run_len = 0;
    if (mode == bpra_pkg::MODE_ALLOC) begin
      if (cnt != 0 && cnt <= pool) begin
        for (int unsigned i = 0; i < pool; i++) begin
          if (page_map[i]) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == cnt) begin
              first = i + 1 - cnt;
              found = 1;
              break;
            end
          end
        end
      end
      if (found) begin
        for (int unsigned k = 0; k < cnt; k++) page_map[first + k] = 1;
        r.run_address = base_reg + (first << bpra_pkg::PAGE_SHIFT);
      end else begin
        r.status = bpra_pkg::ST_NO_SPACE;
      end
    end else begin
      idx = (addr - base_reg) >> bpra_pkg::PAGE_SHIFT;
      if (idx >= pool) begin
        r.status = bpra_pkg::ST_OUTSIDE;
      end else begin
        stop = idx + cnt;
        if (stop > pool) stop = pool;
        for (int unsigned k = idx; k < stop; k++) page_map[k] = 0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_resp_t want;
    if (rst) begin
      base_reg <= bpra_pkg::RESET_BASE;
      pool_reg <= bpra_pkg::RESET_POOL_PAGES;
      for (int i = 0; i < bpra_pkg::MAX_POOL_PAGES; i++) page_map[i] = 0;
      resp_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.reg_index == bpra_pkg::REG_BASE) base_reg <= cfg.data;
        else pool_reg <= cfg.data[bpra_pkg::PAGE_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        if (resp_queue.size() == 0) begin
          $display("%0t: unexpected response status=%0d addr=%h", $time, rsp.status,
                   rsp.run_address);
          fail_count <= fail_count + 1;
        end else begin
          want = resp_queue.pop_front();
          if (want.status !== rsp.status || want.run_address !== rsp.run_address) begin
            $display("%0t: expected status=%0d addr=%h, actual status=%0d addr=%h", $time,
                     want.status, want.run_address, rsp.status, rsp.run_address);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req.valid && req.ready)
        resp_queue.push_back(predict_request(req.mode, req.page_count, req.address));
    end
  end

  assign pending = resp_queue.size();
endmodule

@@ test/testbench.sv @@
// Top of the allocator testbench: clock, reset, request and configuration stimulus,
// response stalls and the verdict. Depends on bpra_pkg, the interfaces and alloc_checker.
module testbench;
  typedef logic [bpra_pkg::PAGE_W-1:0] cnt_t;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int cycle_count;
  bit stall_on;
  logic [31:0] cur_base;

  bpra_req_if req ();
  bpra_rsp_if rsp ();
  bpra_cfg_if cfg ();

  bitmap_page_run_allocator uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  alloc_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                     .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 12000000) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Response side stalls in random bursts unless the run is in its final part.
  initial begin
    rsp.ready = 1;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 9) == 0) begin
        rsp.ready <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      rsp.ready <= 1;
    end
  end

  // The request stays valid after acceptance until the next request or an idle burst.
  task automatic send_request(logic mode, cnt_t cnt, logic [31:0] addr);
    if (stall_on && $urandom_range(0, 7) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req.valid <= 1;
    req.mode <= mode;
    req.page_count <= cnt;
    req.address <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg.valid <= 1;
    cfg.reg_index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
    if (idx == bpra_pkg::REG_BASE) cur_base = value;
  endtask

  function automatic logic [31:0] page_addr(int page);
    return cur_base + (page << bpra_pkg::PAGE_SHIFT) +
           $urandom_range(0, 4095) * $urandom_range(0, 1);
  endfunction

  task automatic random_phase(int n, int pool);
    int cnt;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      unique case (sel)
        0, 1, 2, 3: begin
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) :
                $urandom_range(1, (pool < 64) ? pool + 1 : 64);
          send_request(bpra_pkg::MODE_ALLOC, cnt_t'(cnt), $urandom);
        end
        4, 5, 6, 7:
          send_request(bpra_pkg::MODE_FREE, cnt_t'($urandom_range(0, 64)),
                       page_addr($urandom_range(0, (pool > 0) ? pool - 1 : 0)));
        8:
          send_request(bpra_pkg::MODE_FREE, cnt_t'($urandom_range(0, 32767)), $urandom);
        default:
          send_request(bpra_pkg::MODE_FREE, cnt_t'($urandom_range(0, 32767)), page_addr(0));
      endcase
    end
  endtask

  initial begin
    rst = 1;
    stall_on = 1;
    req.valid = 0;
    req.mode = bpra_pkg::MODE_ALLOC;
    req.page_count = '0;
    req.address = '0;
    cfg.valid = 0;
    cfg.reg_index = bpra_pkg::REG_BASE;
    cfg.data = '0;
    cur_base = bpra_pkg::RESET_BASE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed requests under the reset configuration.
    send_request(bpra_pkg::MODE_ALLOC, 15'd0, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'd1, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'd40, 32'hffff_ffff);
    send_request(bpra_pkg::MODE_ALLOC, 15'd16128, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'd16129, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'h7fff, 32'd0);
    send_request(bpra_pkg::MODE_FREE, 15'd1, bpra_pkg::RESET_BASE + 32'h0fff);
    send_request(bpra_pkg::MODE_FREE, 15'd0, bpra_pkg::RESET_BASE + 32'h1000);
    send_request(bpra_pkg::MODE_FREE, 15'd2, bpra_pkg::RESET_BASE - 32'd1);
    send_request(bpra_pkg::MODE_FREE, 15'd1, 32'hffff_ffff);
    send_request(bpra_pkg::MODE_FREE, 15'h7fff, 32'h0000_0000);
    send_request(bpra_pkg::MODE_FREE, 15'd100,
                 bpra_pkg::RESET_BASE + (32'd16100 << bpra_pkg::PAGE_SHIFT));
    send_request(bpra_pkg::MODE_FREE, 15'h7fff, bpra_pkg::RESET_BASE);
    send_request(bpra_pkg::MODE_ALLOC, 15'd16128, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'd1, 32'd0);
    send_request(bpra_pkg::MODE_FREE, 15'h7fff, bpra_pkg::RESET_BASE);
    drain();

    write_reg(bpra_pkg::REG_POOL, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'd1, 32'd0);
    send_request(bpra_pkg::MODE_FREE, 15'd1, cur_base);
    drain();
    write_reg(bpra_pkg::REG_POOL, 32'h7fff);
    write_reg(bpra_pkg::REG_BASE, 32'hffff_f000);
    send_request(bpra_pkg::MODE_ALLOC, 15'd16384, 32'd0);
    send_request(bpra_pkg::MODE_ALLOC, 15'd1, 32'd0);
    send_request(bpra_pkg::MODE_FREE, 15'h7fff, 32'hffff_f000);
    send_request(bpra_pkg::MODE_ALLOC, 15'd3, 32'd0);
    drain();

    write_reg(bpra_pkg::REG_BASE, 32'd0);
    write_reg(bpra_pkg::REG_POOL, 32'd40);
    random_phase(300, 40);
    drain();
    write_reg(bpra_pkg::REG_BASE, $urandom);
    write_reg(bpra_pkg::REG_POOL, 32'd1);
    random_phase(100, 1);
    drain();
    write_reg(bpra_pkg::REG_BASE, 32'hffff_ffff);
    write_reg(bpra_pkg::REG_POOL, 32'd300);
    random_phase(300, 300);
    drain();
    write_reg(bpra_pkg::REG_BASE, 32'h0100_0000);
    write_reg(bpra_pkg::REG_POOL, 32'd16384);
    random_phase(250, 16384);
    stall_on = 0;
    random_phase(200, 16384);

    drain();
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
